@@ sv/sum8_frame_deframer_unit_assert.svh @@
// ---------------------------------------------------------------------------
// sum8_frame_deframer_unit_assert.svh
// Assertion macros used by the deframer checker.
// ---------------------------------------------------------------------------
`ifndef SUM8_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define SUM8_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SFD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/sfd_pkg.sv @@
// ---------------------------------------------------------------------------
// sfd_pkg
// Types and codes for the length-prefixed sum8 deframer.
// ---------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_VALUE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DROP_FIRST_BODY = 2'd1;

    localparam logic [7:0] HEADER_RESET = 8'h80;
    localparam logic       DROP_RESET   = 1'b1;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_GOOD   = 2'd1,
        KIND_BADHDR = 2'd2,
        KIND_BADSUM = 2'd3
    } kind_t;

    typedef enum logic [5:0] {
        PH_HUNT = 6'b000001,
        PH_DEST = 6'b000010,
        PH_SRC  = 6'b000100,
        PH_SIZE = 6'b001000,
        PH_BODY = 6'b010000,
        PH_CSUM = 6'b100000
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] body_left;
        logic [7:0] run_sum;
        logic       first_pending;
    } frame_state_t;

    typedef struct packed {
        logic       present;
        logic [7:0] out_byte;
        kind_t      kind;
        logic       last;
    } frame_result_t;

endpackage

`default_nettype wire

@@ sv/sfd_if.sv @@
// ---------------------------------------------------------------------------
// sfd_if
// Valid/ready channels of the deframer: received bytes, results, config.
// ---------------------------------------------------------------------------
`default_nettype none

interface sfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;

    modport source (output valid, output out_byte, output kind, output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

interface sfd_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/sfd_step.sv @@
// ---------------------------------------------------------------------------
// sfd_step
// Per-byte frame state update and result decode.
// ---------------------------------------------------------------------------
`default_nettype none

module sfd_step
    import sfd_pkg::*;
(
    input  frame_state_t  st,
    input  logic [7:0]    rx_byte,
    input  logic [7:0]    header_value,
    input  logic          drop_first_body,
    output frame_state_t  st_next,
    output frame_result_t res
);

    logic [7:0] sum_add;
    logic [7:0] left_dec;

    assign sum_add  = st.run_sum + rx_byte;
    assign left_dec = st.body_left - 8'd1;

    always_comb
    begin
        st_next      = st;
        res.present  = 1'b0;
        res.out_byte = 8'd0;
        res.kind     = KIND_DATA;
        res.last     = 1'b0;
        case (st.phase)
            PH_DEST:
            begin
                st_next.run_sum = sum_add;
                st_next.phase   = PH_SRC;
            end
            PH_SRC:
            begin
                st_next.run_sum = sum_add;
                st_next.phase   = PH_SIZE;
            end
            PH_SIZE:
            begin
                st_next.run_sum   = sum_add;
                st_next.body_left = rx_byte;
                if (rx_byte == 8'd0)
                begin
                    st_next.first_pending = 1'b0;
                    st_next.phase         = PH_CSUM;
                end
                else
                begin
                    st_next.first_pending = drop_first_body;
                    st_next.phase         = PH_BODY;
                end
            end
            PH_BODY:
            begin
                st_next.run_sum   = sum_add;
                st_next.body_left = left_dec;
                if (left_dec == 8'd0)
                begin
                    st_next.phase = PH_CSUM;
                end
                // drop the response command byte, still counted in the sum
                if (st.first_pending)
                begin
                    st_next.first_pending = 1'b0;
                end
                else
                begin
                    res.present  = 1'b1;
                    res.out_byte = rx_byte;
                end
            end
            PH_CSUM:
            begin
                st_next.phase   = PH_HUNT;
                st_next.run_sum = 8'd0;
                res.present     = 1'b1;
                res.last        = 1'b1;
                res.kind        = (rx_byte == st.run_sum) ? KIND_GOOD : KIND_BADSUM;
            end
            default:
            begin
                st_next.phase = PH_HUNT;
                if (rx_byte == header_value)
                begin
                    st_next.run_sum       = rx_byte;
                    st_next.body_left     = 8'd0;
                    st_next.first_pending = 1'b0;
                    st_next.phase         = PH_DEST;
                end
                else
                begin
                    res.present = 1'b1;
                    res.last    = 1'b1;
                    res.kind    = KIND_BADHDR;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/sum8_frame_deframer_unit.sv @@
// ---------------------------------------------------------------------------
// sum8_frame_deframer_unit
// Path: a byte accepted into the input register passes through the step logic
// into the output register once that is free, and is then offered to the sink.
// Throughput: one byte per cycle while the sink keeps ready high; a waiting
// result holds the step, the input register takes one more byte, then stalls.
// Reset: rst_n clears the frame state to hunting and restores the config registers.
// ---------------------------------------------------------------------------
`default_nettype none

module sum8_frame_deframer_unit
    import sfd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    sfd_rx_if.sink    rx,
    sfd_tx_if.source  tx,
    sfd_cfg_if.sink   cfg
);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    frame_state_t  st_reg;
    frame_state_t  st_next;
    frame_result_t res;
    logic [7:0]    header_reg;
    logic          drop_reg;
    logic          out_valid_reg;
    frame_result_t out_reg;
    logic          out_free;
    logic          advance;

    sfd_step u_step (
        .st              (st_reg),
        .rx_byte         (in_byte_reg),
        .header_value    (header_reg),
        .drop_first_body (drop_reg),
        .st_next         (st_next),
        .res             (res)
    );

    assign out_free = !out_valid_reg || tx.ready;
    assign advance  = in_valid_reg && out_free;
    assign rx.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    assign tx.valid    = out_valid_reg;
    assign tx.out_byte = out_reg.out_byte;
    assign tx.kind     = out_reg.kind;
    assign tx.last     = out_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
            drop_reg   <= DROP_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_HEADER_VALUE:    header_reg <= cfg.data;
                REG_DROP_FIRST_BODY: drop_reg   <= cfg.data[0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '{phase: PH_HUNT, body_left: 8'd0, run_sum: 8'd0,
                               first_pending: 1'b0};
        end
        else
        begin
            if (rx.ready)
            begin
                in_valid_reg <= rx.valid;
            end
            if (advance)
            begin
                st_reg <= st_next;
            end
            if (out_free)
            begin
                out_valid_reg <= advance && res.present;
            end
        end
    end

    // payload registers: hold while stalled
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (advance && res.present)
        begin
            out_reg <= res;
        end
    end

endmodule

`default_nettype wire

@@ sv/sfd_checker.sv @@
// ---------------------------------------------------------------------------
// sfd_checker
// Port-level checks on the deframer result channel, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sum8_frame_deframer_unit_assert.svh"

module sfd_checker
    import sfd_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       tx_valid,
    input wire logic       tx_ready,
    input wire logic [7:0] tx_out_byte,
    input wire logic [1:0] tx_kind,
    input wire logic       tx_last
);

    // payload words never close a frame
    `SFD_ASSERT_SAME(a_data_not_last, tx_valid && (tx_kind == KIND_DATA), !tx_last, "payload word marked last")

    // status words are closing words with a zero byte
    `SFD_ASSERT_SAME(a_status_shape, tx_valid && (tx_kind != KIND_DATA), tx_last && (tx_out_byte == 8'd0), "status word malformed")

    // a stalled word holds
    `SFD_ASSERT_NEXT(a_hold_stall, tx_valid && !tx_ready, tx_valid && $stable(tx_out_byte) && $stable(tx_kind) && $stable(tx_last), "stalled word changed")

endmodule

bind sum8_frame_deframer_unit sfd_checker u_sfd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .tx_valid    (tx.valid),
    .tx_ready    (tx.ready),
    .tx_out_byte (tx.out_byte),
    .tx_kind     (tx.kind),
    .tx_last     (tx.last)
);

`default_nettype wire

@@ tb/tb_sum8_frame_deframer_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sum8_frame_deframer_unit
// Self-checking bench for the length-prefixed sum8 deframer. Frames, noise
// and broken frames go in on the receive channel. A shadow of the deframer
// state predicts every payload byte and frame verdict. Each word leaving the
// block is checked in order against that prediction, while both sides stall
// at random and the header and drop registers move through their range.
// ---------------------------------------------------------------------------

module tb_sum8_frame_deframer_unit;
    import sfd_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int QUIET_CYCLES  = 4;
    localparam int RANDOM_BYTES  = 575;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      kind;
        logic       last;
    } deframed_t;

    logic clk;
    logic rst_n;

    sfd_rx_if  rx_bus ();
    sfd_tx_if  tx_bus ();
    sfd_cfg_if cfg_bus ();

    sum8_frame_deframer_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_bus),
        .tx    (tx_bus),
        .cfg   (cfg_bus)
    );

    // shadow of the deframer registers and frame state
    logic [7:0] hdr_reg     = HEADER_RESET;
    logic       drop_reg    = DROP_RESET;
    phase_t     frame_phase = PH_HUNT;
    logic [7:0] bytes_to_go = 8'h00;
    logic [7:0] sum_acc     = 8'h00;
    logic       skip_next   = 1'b0;

    deframed_t deframed_q[$];

    int errors       = 0;
    int bytes_sent   = 0;
    int n_payload    = 0;
    int n_good       = 0;
    int n_badsum     = 0;
    int n_badhdr     = 0;
    int n_settings   = 0;
    int rx_gap_max   = 0;
    int tx_stall_max = 0;
    int hold_cycles  = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("%0t: timeout, %0d results still outstanding", $time, deframed_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // -----------------------------------------------------------------------
    // prediction
    // -----------------------------------------------------------------------
    function automatic void deframe_byte(input logic [7:0] b);
        deframed_t r;
        bit        has_r;
        has_r = 1'b0;
        r = '{8'h00, KIND_DATA, 1'b0};
        case (frame_phase)
            PH_DEST:
            begin
                sum_acc += b;
                frame_phase = PH_SRC;
            end
            PH_SRC:
            begin
                sum_acc += b;
                frame_phase = PH_SIZE;
            end
            PH_SIZE:
            begin
                sum_acc += b;
                bytes_to_go = b;
                if (b == 8'h00)
                begin
                    skip_next = 1'b0;
                    frame_phase = PH_CSUM;
                end
                else
                begin
                    // drop option is latched here
                    skip_next = drop_reg;
                    frame_phase = PH_BODY;
                end
            end
            PH_BODY:
            begin
                sum_acc += b;
                bytes_to_go -= 8'd1;
                if (bytes_to_go == 8'h00)
                    frame_phase = PH_CSUM;
                if (skip_next)
                    skip_next = 1'b0;
                else
                begin
                    r.out_byte = b;
                    has_r = 1'b1;
                end
            end
            PH_CSUM:
            begin
                frame_phase = PH_HUNT;
                r.kind = (b == sum_acc) ? KIND_GOOD : KIND_BADSUM;
                r.last = 1'b1;
                has_r = 1'b1;
                sum_acc = 8'h00;
            end
            default:
            begin
                if (b == hdr_reg)
                begin
                    sum_acc = b;
                    bytes_to_go = 8'h00;
                    skip_next = 1'b0;
                    frame_phase = PH_DEST;
                end
                else
                begin
                    frame_phase = PH_HUNT;
                    r.kind = KIND_BADHDR;
                    r.last = 1'b1;
                    has_r = 1'b1;
                end
            end
        endcase
        if (has_r)
            deframed_q = {deframed_q, r};
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_HEADER_VALUE:    hdr_reg = value;
            REG_DROP_FIRST_BODY: drop_reg = value[0];
            default:             ;
        endcase
    endfunction

    function automatic void check_deframed();
        deframed_t want;
        if (deframed_q.size() == 0)
        begin
            $display("%0t: unexpected word out_byte=%02h kind=%0d last=%0b",
                     $time, tx_bus.out_byte, tx_bus.kind, tx_bus.last);
            errors++;
            return;
        end
        want = deframed_q.pop_front();
        if (tx_bus.out_byte !== want.out_byte)
        begin
            $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                     $time, want.out_byte, tx_bus.out_byte);
            errors++;
        end
        if (tx_bus.kind !== want.kind)
        begin
            $display("%0t: kind mismatch, expected %0d, actual %0d",
                     $time, want.kind, tx_bus.kind);
            errors++;
        end
        if (tx_bus.last !== want.last)
        begin
            $display("%0t: last mismatch, expected %0b, actual %0b",
                     $time, want.last, tx_bus.last);
            errors++;
        end
        case (want.kind)
            KIND_DATA:   n_payload++;
            KIND_GOOD:   n_good++;
            KIND_BADSUM: n_badsum++;
            default:     n_badhdr++;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tx_bus.valid && tx_bus.ready)
                check_deframed();
            if (cfg_bus.valid && cfg_bus.ready)
                apply_reg(cfg_bus.index, cfg_bus.data);
            if (rx_bus.valid && rx_bus.ready)
                deframe_byte(rx_bus.rx_byte);
        end
    end

    // -----------------------------------------------------------------------
    // result side: random stalls, plus a long hold-off on request
    // -----------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        tx_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                tx_bus.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            stall = $urandom_range(0, tx_stall_max);
            if (stall > 0)
            begin
                tx_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            tx_bus.ready <= 1'b1;
            @(posedge clk);
            while (!tx_bus.valid && hold_cycles == 0)
                @(posedge clk);
        end
    end

    // -----------------------------------------------------------------------
    // stimulus helpers
    // -----------------------------------------------------------------------
    // valid stays high when the next word follows with no gap
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, rx_gap_max);
        if (gap > 0)
        begin
            rx_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_bus.valid   <= 1'b1;
        rx_bus.rx_byte <= b;
        @(posedge clk);
        while (!rx_bus.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // keep < 0 sends the whole frame, otherwise only its first keep words
    task automatic send_frame(input logic [7:0] dest, input logic [7:0] src,
                              input byte_q_t body, input bit bad_sum, input int keep);
        byte_q_t    words;
        logic [7:0] sum;
        int         stop;
        words = {hdr_reg, dest, src, 8'(body.size())};
        foreach (body[i])
            words = {words, body[i]};
        sum = 8'h00;
        foreach (words[i])
            sum += words[i];
        if (bad_sum)
            sum += 8'($urandom_range(1, 255));
        words = {words, sum};
        stop = (keep < 0 || keep > words.size()) ? words.size() : keep;
        for (int i = 0; i < stop; i++)
            send_byte(words[i]);
    endtask

    function automatic byte_q_t random_body(input int n);
        byte_q_t q;
        for (int i = 0; i < n; i++)
            q = {q, 8'($urandom)};
        return q;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
    endtask

    // upper data bits of the drop register are noise
    task automatic write_regs(input logic [7:0] hdr, input logic drop, input bit spare);
        write_reg(REG_HEADER_VALUE, hdr);
        write_reg(REG_DROP_FIRST_BODY, {7'($urandom), drop});
        if (spare)
        begin
            write_reg(REG_SPARE_A, 8'($urandom));
            write_reg(REG_SPARE_B, 8'($urandom));
        end
        cfg_bus.valid <= 1'b0;
        n_settings++;
    endtask

    // hold the input until every predicted word is out, then let it settle
    task automatic wait_quiet();
        rx_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (deframed_q.size() != 0);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // -----------------------------------------------------------------------
    // tests
    // -----------------------------------------------------------------------
    task automatic test_directed_cases();
        byte_q_t body;
        rx_gap_max = 0;
        tx_stall_max = 0;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h7F);
        body = {8'h11, 8'h00, 8'hFF};
        send_frame(8'hFF, 8'h00, body, 1'b0, -1);
        body = {};
        send_frame(8'h01, 8'h02, body, 1'b1, -1);
        body = {8'hAA};
        send_frame(8'h00, 8'h00, body, 1'b0, -1);
        wait_quiet();
    endtask

    task automatic test_register_settings();
        byte_q_t body;
        rx_gap_max = 17;
        tx_stall_max = 17;
        write_regs(8'h00, 1'b0, 1'b0);
        send_frame(8'h12, 8'h34, random_body(4), 1'b0, -1);
        send_byte(HEADER_RESET);
        body = {};
        send_frame(8'hFE, 8'h01, body, 1'b0, -1);
        wait_quiet();

        write_regs(8'hFF, 1'b1, 1'b1);
        send_frame(8'($urandom), 8'($urandom), random_body(2), 1'b0, -1);
        send_frame(8'($urandom), 8'($urandom), random_body(5), 1'b1, -1);
        send_byte(8'h00);
        wait_quiet();

        // change both registers between address and size words
        write_regs(8'h5A, 1'b0, 1'b0);
        body = {8'h33, 8'h44};
        send_frame(8'h01, 8'h02, body, 1'b0, 3);
        wait_quiet();
        write_regs(8'h3C, 1'b1, 1'b0);
        send_byte(8'h02);
        send_byte(8'h33);
        send_byte(8'h44);
        send_byte(8'hD6);
        send_byte(8'h5A);
        send_frame(8'($urandom), 8'($urandom), random_body(3), 1'b0, -1);
        wait_quiet();
    endtask

    task automatic test_backpressure();
        wait_quiet();
        write_regs(8'($urandom), 1'b0, 1'b0);
        rx_gap_max = 0;
        tx_stall_max = 0;
        // long hold-off on the result side while a full-size frame streams in
        hold_cycles = 150;
        send_frame(8'($urandom), 8'($urandom), random_body(255), 1'b0, -1);
        wait_quiet();
        tx_stall_max = 17;
        hold_cycles = 60;
        send_frame(8'($urandom), 8'($urandom), random_body(40), 1'b1, -1);
        wait_quiet();
    endtask

    task automatic test_random_traffic();
        int         target;
        int         last_cfg;
        int         pick;
        int         size;
        int         n;
        logic [7:0] b;
        logic [7:0] hdr;
        byte_q_t    body;
        target = bytes_sent + RANDOM_BYTES;
        last_cfg = bytes_sent;
        while (bytes_sent < target)
        begin
            if (bytes_sent - last_cfg >= 100)
            begin
                wait_quiet();
                case ($urandom_range(0, 3))
                    0:       hdr = 8'h00;
                    1:       hdr = 8'hFF;
                    default: hdr = 8'($urandom);
                endcase
                write_regs(hdr, 1'($urandom), ($urandom_range(0, 3) == 0));
                last_cfg = bytes_sent;
            end
            case ($urandom_range(0, 3))
                0:       rx_gap_max = 0;
                1:       rx_gap_max = 2;
                default: rx_gap_max = 17;
            endcase
            case ($urandom_range(0, 3))
                0:       tx_stall_max = 0;
                1:       tx_stall_max = 2;
                default: tx_stall_max = 17;
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                // noise between frames
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                begin
                    b = 8'($urandom);
                    if (b == hdr_reg)
                        b = ~b;
                    send_byte(b);
                end
            end
            else
            begin
                size = ($urandom_range(0, 149) == 0) ? $urandom_range(200, 255)
                                                     : $urandom_range(0, 12);
                body = random_body(size);
                if (pick < 14)
                    send_frame(8'($urandom), 8'($urandom), body, 1'b0,
                               $urandom_range(1, size + 4));
                else
                    send_frame(8'($urandom), 8'($urandom), body,
                               ($urandom_range(0, 99) < 15), -1);
            end
        end
        wait_quiet();
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        rx_bus.valid   <= 1'b0;
        rx_bus.rx_byte <= 8'h00;
        cfg_bus.valid  <= 1'b0;
        cfg_bus.index  <= REG_HEADER_VALUE;
        cfg_bus.data   <= 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_register_settings();
        test_backpressure();
        test_random_traffic();

        $display("Sent %0d bytes over %0d register settings; checked %0d payload bytes,",
                 bytes_sent, n_settings, n_payload);
        $display("%0d good frames, %0d bad checksums, %0d bad headers",
                 n_good, n_badsum, n_badhdr);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/sfd_pkg.sv
sv/sfd_if.sv
sv/sfd_step.sv
sv/sum8_frame_deframer_unit.sv
sv/sfd_checker.sv
tb/tb_sum8_frame_deframer_unit.sv
